// File: rtl/bdd_pkg.sv
// shared types and constants for the delayed duplicate filter
// no dependencies; used by the top level
package bdd_pkg;

    localparam int KEY_BITS_DEF = 64;
    localparam int CAPACITY_DEF = 4096;

    typedef enum logic [1:0] {
        REQ_SEED   = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_CLOSE  = 2'd2,
        REQ_READ   = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type   req_type;
        logic [63:0] state_key;
        logic [11:0] entry_index;
    } t_req;

    typedef struct packed {
        logic [63:0] entry_key;
        logic [12:0] frontier_size;
        logic [12:0] total_visited;
        logic [11:0] level;
        logic        store_full;
        logic        search_done;
    } t_res;

endpackage

// File: rtl/bdd_ram_2r.sv
// key store memory: one write port, two registered read ports
// no package dependencies
module bdd_ram_2r #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 64,
    parameter int AW    = 12
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wa,
    input  logic [WIDTH-1:0] i_wd,
    input  logic [AW-1:0]    i_ra,
    input  logic [AW-1:0]    i_rb,
    output logic [WIDTH-1:0] o_qa,
    output logic [WIDTH-1:0] o_qb
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_qa;
    logic [WIDTH-1:0] r_qb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        r_qa <= r_mem[i_ra];
        r_qb <= r_mem[i_rb];
    end

    assign o_qa = r_qa;
    assign o_qb = r_qb;

endmodule

// File: rtl/bdd_ram_1r.sv
// scratch memory: one write port, one registered read port
// no package dependencies
module bdd_ram_1r #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 64,
    parameter int AW    = 12
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wa,
    input  logic [WIDTH-1:0] i_wd,
    input  logic [AW-1:0]    i_ra,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        r_q <= r_mem[i_ra];
    end

    assign o_q = r_q;

endmodule

// File: rtl/bfs_delayed_duplicate_filter.sv
// seed, insert and read give their result in the cycle after the transaction;
// one such request can be taken every cycle while the sequencer is idle
// close level: batch merge sort, then merge of old list and frontier, then a filter of
// batch keys against both lists, then copy back to the store; each memory has a single write
// port. synchronous reset clears the sequencer state, counts and flags only;
// store contents are undefined until written. the receiver cannot stall results
module bfs_delayed_duplicate_filter #(
    parameter int KEY_BITS = bdd_pkg::KEY_BITS_DEF,
    parameter int CAPACITY = bdd_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  bdd_pkg::t_req i_req,
    output logic          busy,
    output logic          o_strobe,
    output bdd_pkg::t_res o_res
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = CW + 2;
    localparam int XW = (PW > 12) ? PW : 12;

    typedef enum logic [3:0] {
        ST_IDLE, ST_GRP, ST_SRD, ST_SWR, ST_SCRD, ST_SCWR, ST_MRD, ST_MWR,
        ST_FRDV, ST_FLAT, ST_FRD, ST_FCMP, ST_CRD, ST_CWR
    } t_state;

    t_state r_state;

    // architectural counts
    logic [CW-1:0] r_old, r_front, r_batch, r_total;
    logic [11:0]   r_level;
    logic          r_full;

    // result register
    logic r_strobe, r_rd_hit;

    // sequencer positions
    logic [PW-1:0] r_w, r_lo, r_hi, r_i, r_j, r_k, r_m, r_po, r_pf, r_kept;
    logic [KEY_BITS-1:0] r_v, r_last;
    logic r_prev_ok;

    // memory ports
    logic                k_we;
    logic [AW-1:0]       k_wa, k_ra, k_rb;
    logic [KEY_BITS-1:0] k_wd, k_qa, k_qb;
    logic                s_we;
    logic [AW-1:0]       s_wa, s_ra;
    logic [KEY_BITS-1:0] s_wd, s_q;

    logic                accept;
    logic [KEY_BITS-1:0] w_key;
    logic [PW-1:0]       w_b0, w_n, w_used, w_old, w_front, w_mid_a, w_mid, w_hi_a, w_hi;
    logic                take_j, m_take_a, m_wr, f_adv_o, f_adv_f, f_dup;
    logic [KEY_BITS-1:0] m_v;
    logic                rd_hit;

    assign accept  = start && !busy;
    assign w_key   = i_req.state_key[KEY_BITS-1:0];
    assign w_old   = PW'(r_old);
    assign w_front = PW'(r_front);
    assign w_n     = PW'(r_batch);
    assign w_b0    = w_old + w_front;
    assign w_used  = w_b0 + w_n;
    assign rd_hit  = XW'(i_req.entry_index) < XW'(r_front);

    // merge group bounds for the batch sort
    assign w_mid_a = r_lo + r_w;
    assign w_mid   = (w_mid_a > w_n) ? w_n : w_mid_a;
    assign w_hi_a  = w_mid + r_w;
    assign w_hi    = (w_hi_a > w_n) ? w_n : w_hi_a;

    // sort step: take right run when left run is exhausted or right key is strictly smaller (stable)
    assign take_j   = (r_j < r_hi) && ((r_i >= r_lo + r_w) || (k_qb < k_qa));
    // old/frontier merge step
    assign m_take_a = (r_j >= w_front) || ((r_i < w_old) && (k_qa <= k_qb));
    assign m_v      = m_take_a ? k_qa : k_qb;
    assign m_wr     = (r_m == '0) || (r_last != m_v);
    // filter step against old list and frontier
    assign f_adv_o  = (r_po < w_old) && (k_qa < r_v);
    assign f_adv_f  = (r_pf < w_front) && (k_qb < r_v);
    assign f_dup    = ((r_po < w_old) && (k_qa == r_v)) || ((r_pf < w_front) && (k_qb == r_v));

    // memory port steering
    always_comb begin
        k_we = 1'b0;
        k_wa = '0;
        k_wd = w_key;
        k_ra = AW'(w_old + PW'(i_req.entry_index));
        k_rb = '0;
        s_we = 1'b0;
        s_wa = '0;
        s_wd = k_qa;
        s_ra = AW'(r_k);
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_req.req_type == bdd_pkg::REQ_SEED) begin
                    k_we = 1'b1;
                end else if (accept && i_req.req_type == bdd_pkg::REQ_INSERT) begin
                    k_we = w_used < PW'(CAPACITY);
                    k_wa = AW'(w_used);
                end
            end
            ST_SRD: begin
                k_ra = AW'(w_b0 + r_i);
                k_rb = AW'(w_b0 + r_j);
            end
            ST_SWR: begin
                s_we = 1'b1;
                s_wa = AW'(r_k);
                s_wd = take_j ? k_qb : k_qa;
            end
            ST_SCWR: begin
                k_we = 1'b1;
                k_wa = AW'(w_b0 + r_k);
                k_wd = s_q;
            end
            ST_MRD: begin
                k_ra = AW'(r_i);
                k_rb = AW'(w_old + r_j);
            end
            ST_MWR: begin
                s_we = m_wr;
                s_wa = AW'(r_m);
                s_wd = m_v;
            end
            ST_FRDV: begin
                k_ra = AW'(w_b0 + r_i);
            end
            ST_FRD: begin
                k_ra = AW'(r_po);
                k_rb = AW'(w_old + r_pf);
            end
            ST_FCMP: begin
                s_we = !f_adv_o && !f_adv_f && !f_dup;
                s_wa = AW'(r_m + r_kept);
                s_wd = r_v;
            end
            ST_CWR: begin
                k_we = 1'b1;
                k_wa = AW'(r_k);
                k_wd = s_q;
            end
            default: begin
            end
        endcase
    end

    bdd_ram_2r #(.DEPTH(CAPACITY), .WIDTH(KEY_BITS), .AW(AW)) u_key_store (
        .i_clk (i_clk),
        .i_we  (k_we),
        .i_wa  (k_wa),
        .i_wd  (k_wd),
        .i_ra  (k_ra),
        .i_rb  (k_rb),
        .o_qa  (k_qa),
        .o_qb  (k_qb)
    );

    bdd_ram_1r #(.DEPTH(CAPACITY), .WIDTH(KEY_BITS), .AW(AW)) u_scratch (
        .i_clk (i_clk),
        .i_we  (s_we),
        .i_wa  (s_wa),
        .i_wd  (s_wd),
        .i_ra  (s_ra),
        .o_q   (s_q)
    );

    // sequencer, counts and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_old    <= '0;
            r_front  <= '0;
            r_batch  <= '0;
            r_total  <= '0;
            r_level  <= '0;
            r_full   <= 1'b0;
            r_strobe <= 1'b0;
            r_rd_hit <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_rd_hit <= 1'b0;
                        unique case (i_req.req_type)
                            bdd_pkg::REQ_SEED: begin
                                r_old    <= '0;
                                r_front  <= CW'(1);
                                r_batch  <= '0;
                                r_total  <= CW'(1);
                                r_level  <= '0;
                                r_full   <= 1'b0;
                                r_strobe <= 1'b1;
                            end
                            bdd_pkg::REQ_INSERT: begin
                                if (w_used >= PW'(CAPACITY)) begin
                                    r_full <= 1'b1;
                                end else begin
                                    r_batch <= r_batch + CW'(1);
                                end
                                r_strobe <= 1'b1;
                            end
                            bdd_pkg::REQ_READ: begin
                                r_rd_hit <= rd_hit;
                                r_strobe <= 1'b1;
                            end
                            bdd_pkg::REQ_CLOSE: begin
                                r_i <= '0;
                                r_j <= '0;
                                r_m <= '0;
                                if (w_n > PW'(1)) begin
                                    r_w     <= PW'(1);
                                    r_lo    <= '0;
                                    r_state <= ST_GRP;
                                end else begin
                                    r_state <= ST_MRD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                // batch merge sort: one pass merges runs of r_w into scratch
                ST_GRP: begin
                    if (r_lo >= w_n) begin
                        r_k     <= '0;
                        r_state <= ST_SCRD;
                    end else begin
                        r_hi    <= w_hi;
                        r_i     <= r_lo;
                        r_j     <= w_mid;
                        r_k     <= r_lo;
                        r_state <= ST_SRD;
                    end
                end
                ST_SRD: begin
                    r_state <= ST_SWR;
                end
                ST_SWR: begin
                    r_k <= r_k + PW'(1);
                    if (take_j) begin
                        r_j <= r_j + PW'(1);
                    end else begin
                        r_i <= r_i + PW'(1);
                    end
                    if (r_k + PW'(1) == r_hi) begin
                        r_lo    <= r_lo + (r_w << 1);
                        r_state <= ST_GRP;
                    end else begin
                        r_state <= ST_SRD;
                    end
                end
                ST_SCRD: begin
                    r_state <= ST_SCWR;
                end
                // copy pass result back into the batch area
                ST_SCWR: begin
                    r_k <= r_k + PW'(1);
                    if (r_k + PW'(1) == w_n) begin
                        if ((r_w << 1) < w_n) begin
                            r_w     <= r_w << 1;
                            r_lo    <= '0;
                            r_state <= ST_GRP;
                        end else begin
                            r_i     <= '0;
                            r_j     <= '0;
                            r_m     <= '0;
                            r_state <= ST_MRD;
                        end
                    end else begin
                        r_state <= ST_SCRD;
                    end
                end
                // merge old list and frontier into scratch, unique
                ST_MRD: begin
                    if (r_i >= w_old && r_j >= w_front) begin
                        r_i       <= '0;
                        r_po      <= '0;
                        r_pf      <= '0;
                        r_kept    <= '0;
                        r_prev_ok <= 1'b0;
                        r_state   <= ST_FRDV;
                    end else begin
                        r_state <= ST_MWR;
                    end
                end
                ST_MWR: begin
                    if (m_take_a) begin
                        r_i <= r_i + PW'(1);
                    end else begin
                        r_j <= r_j + PW'(1);
                    end
                    if (m_wr) begin
                        r_m <= r_m + PW'(1);
                    end
                    r_last  <= m_v;
                    r_state <= ST_MRD;
                end
                // filter sorted batch: skip repeats and keys already seen
                ST_FRDV: begin
                    if (r_i >= w_n) begin
                        r_k     <= '0;
                        r_state <= ST_CRD;
                    end else begin
                        r_state <= ST_FLAT;
                    end
                end
                ST_FLAT: begin
                    if (r_prev_ok && k_qa == r_v) begin
                        r_i     <= r_i + PW'(1);
                        r_state <= ST_FRDV;
                    end else begin
                        r_v       <= k_qa;
                        r_prev_ok <= 1'b1;
                        r_state   <= ST_FRD;
                    end
                end
                ST_FRD: begin
                    r_state <= ST_FCMP;
                end
                ST_FCMP: begin
                    if (f_adv_o) begin
                        r_po    <= r_po + PW'(1);
                        r_state <= ST_FRD;
                    end else if (f_adv_f) begin
                        r_pf    <= r_pf + PW'(1);
                        r_state <= ST_FRD;
                    end else begin
                        if (!f_dup) begin
                            r_kept <= r_kept + PW'(1);
                        end
                        r_i     <= r_i + PW'(1);
                        r_state <= ST_FRDV;
                    end
                end
                // copy merged list and new frontier back to the store
                ST_CRD: begin
                    if (r_k == r_m + r_kept) begin
                        r_old    <= CW'(r_m);
                        r_front  <= CW'(r_kept);
                        r_batch  <= '0;
                        r_total  <= CW'(r_m + r_kept);
                        r_level  <= r_level + 12'd1;
                        r_rd_hit <= 1'b0;
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_state <= ST_CWR;
                    end
                end
                ST_CWR: begin
                    r_k     <= r_k + PW'(1);
                    r_state <= ST_CRD;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;

    always_comb begin
        o_res.entry_key     = r_rd_hit ? 64'(k_qa) : 64'd0;
        o_res.frontier_size = 13'(r_front);
        o_res.total_visited = 13'(r_total);
        o_res.level         = r_level;
        o_res.store_full    = r_full;
        o_res.search_done   = (r_front == '0);
    end

    // a result is only presented once the sequencer is back in idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // seed, insert and read requests answer on the next cycle
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.req_type != bdd_pkg::REQ_CLOSE) |=> o_strobe)
        else $error("missing result for single-cycle request");

    // the three lists never overrun the store
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (PW'(r_old) + PW'(r_front) + PW'(r_batch)) <= PW'(CAPACITY))
        else $error("store lists exceed capacity");

    // full flag is sticky until a seed
    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && !(start && !busy && i_req.req_type == bdd_pkg::REQ_SEED)) |=> r_full)
        else $error("full flag cleared without seed");

endmodule
